// ===== hdl/nearest_neighbor_image_resize_assert.svh =====
// Assertion macros for the nearest neighbor image resizer.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef NEAREST_NEIGHBOR_IMAGE_RESIZE_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_RESIZE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NNIR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NNIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/nnir_pkg.sv =====
// Shared types and constants of the nearest neighbor image resizer.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package nnir_pkg;

  localparam int DEF_MAX_DIM    = 256;
  localparam int DEF_MAX_PIXELS = 65536;

  localparam int CFG_DIM_W  = 9;
  localparam int PB_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int PIX_W      = 32;
  localparam int STATUS_W   = 2;

  localparam logic [CFG_DIM_W-1:0] CFG_DIM_RESET = 9'd256;
  localparam logic [PB_W-1:0]      PB_RESET      = 3'd1;

  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NARROW = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_SHORT  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT,
    REG_PIXEL_BYTES
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIX,
    ST_MULX,
    ST_DIVX,
    ST_MULY,
    ST_DIVY,
    ST_MULA,
    ST_MULE,
    ST_READ,
    ST_EMIT,
    ST_ERR
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_FIX,
    OP_MULX,
    OP_MULY,
    OP_MULA,
    OP_MULE,
    OP_STEP,
    OP_READ,
    OP_EMIT,
    OP_ERR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                enlarge;
    logic                div_done;
    logic                out_full;
  } sts_t;

endpackage

// ===== hdl/nnir_ctrl.sv =====
// Controller state machine of the nearest neighbor image resizer.
// Depends on nnir_pkg; drives the datapath commands and the input ready.
`timescale 1ns / 1ps

module nnir_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_req_type,
  output logic          in_ready,
  input  nnir_pkg::sts_t sts_i,
  output nnir_pkg::cmd_t cmd_o
);
  import nnir_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_req_type) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        if (sts_i.status != STAT_OK) begin
          state_nxt = ST_ERR;
        end else if (sts_i.enlarge) begin
          state_nxt = ST_MULE;
        end else begin
          state_nxt = ST_MULX;
        end
      end
      ST_MULX: state_nxt = ST_DIVX;
      ST_DIVX: begin
        if (sts_i.div_done) begin
          state_nxt = ST_MULY;
        end
      end
      ST_MULY: state_nxt = ST_DIVY;
      ST_DIVY: begin
        if (sts_i.div_done) begin
          state_nxt = ST_MULA;
        end
      end
      ST_MULA: state_nxt = ST_READ;
      ST_MULE: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EMIT;
      ST_EMIT, ST_ERR: begin
        if (!sts_i.out_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd_o.load = in_valid && !in_req_type;
      end
      ST_FIX:  cmd_o.op = OP_FIX;
      ST_MULX: cmd_o.op = OP_MULX;
      ST_MULY: cmd_o.op = OP_MULY;
      ST_MULA: cmd_o.op = OP_MULA;
      ST_MULE: cmd_o.op = OP_MULE;
      ST_DIVX, ST_DIVY: begin
        cmd_o.op = sts_i.div_done ? OP_NONE : OP_STEP;
      end
      ST_READ: cmd_o.op = OP_READ;
      ST_EMIT: cmd_o.op = sts_i.out_full ? OP_NONE : OP_EMIT;
      ST_ERR:  cmd_o.op = sts_i.out_full ? OP_NONE : OP_ERR;
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ===== hdl/nnir_dp.sv =====
// Datapath of the nearest neighbor image resizer: configuration, frame store,
// position counters, multiplier, shared bit-serial divider and result register.
// Depends on nnir_pkg; steered by nnir_ctrl.
`timescale 1ns / 1ps

module nnir_dp #(
  parameter int MAX_DIM    = nnir_pkg::DEF_MAX_DIM,
  parameter int MAX_PIXELS = nnir_pkg::DEF_MAX_PIXELS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  nnir_pkg::cmd_t                     cmd_i,
  output nnir_pkg::sts_t                     sts_o,
  input  logic                               cfg_valid,
  input  logic [nnir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nnir_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [nnir_pkg::PIX_W-1:0]         in_src_pixel,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [nnir_pkg::PIX_W-1:0]         out_pixel,
  output logic [nnir_pkg::STATUS_W-1:0]      out_status,
  output logic                               out_last
);
  import nnir_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CW     = $clog2(MAX_DIM);
  localparam int PW     = 2 * DIM_W;
  localparam int PIX_AW = $clog2(MAX_PIXELS);
  localparam int DV_W   = DIM_W;
  localparam int CNT_W  = $clog2(PW + 1);
  localparam int CMP_W  = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (ve > CMP_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(ve);
  endfunction

  logic [CFG_DIM_W-1:0] src_w_r, src_w_nxt;
  logic [CFG_DIM_W-1:0] src_h_r, src_h_nxt;
  logic [CFG_DIM_W-1:0] dst_w_r, dst_w_nxt;
  logic [CFG_DIM_W-1:0] dst_h_r, dst_h_nxt;
  logic [PB_W-1:0]      pb_r, pb_nxt;

  logic [CW-1:0]     col_r, col_nxt;
  logic [CW-1:0]     row_r, row_nxt;
  logic [PIX_AW-1:0] load_idx_r, load_idx_nxt;

  logic [PW-1:0]    prod_r, prod_nxt;
  logic [DV_W-1:0]  rem_r, rem_nxt;
  logic [DV_W-1:0]  divisor_r, divisor_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIM_W-1:0] qx_r, qx_nxt;

  logic [PIX_W-1:0]    rdata_r;
  logic                out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]    out_pixel_r, out_pixel_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  logic [PIX_W-1:0] mem [MAX_PIXELS];

  logic [DIM_W-1:0]    sw, sh, dw, dh;
  logic [DIM_W-1:0]    col_e, row_e, tx, ty, ex, ey;
  logic [DIM_W:0]      tx_end, ty_end;
  logic [DIM_W-1:0]    col_inc, row_inc;
  logic                in_box, pos_bad, wrap_col, frame_end, enlarge;
  logic [STATUS_W-1:0] status;
  logic [PIX_W-1:0]    mask;
  logic [PW-1:0]       mul_x, mul_y, mul_a, mul_e;
  logic [DV_W:0]       rem_sh;
  logic                rem_ge;
  logic [PIX_AW-1:0]   rd_addr;

  always_comb begin
    sw = clamp_dim(src_w_r);
    sh = clamp_dim(src_h_r);
    dw = clamp_dim(dst_w_r);
    dh = clamp_dim(dst_h_r);

    case (pb_r)
      3'd0, 3'd1: mask = 32'h0000_00FF;
      3'd2:       mask = 32'h0000_FFFF;
      3'd3:       mask = 32'h00FF_FFFF;
      default:    mask = 32'hFFFF_FFFF;
    endcase

    enlarge = (dw > sw) || (dh > sh);
    status  = STAT_OK;
    if (enlarge) begin
      if (dw < sw) begin
        status = STAT_NARROW;
      end else if (dh < sh) begin
        status = STAT_SHORT;
      end
    end

    col_e     = DIM_W'(col_r);
    row_e     = DIM_W'(row_r);
    pos_bad   = (col_e >= dw) || (row_e >= dh);
    col_inc   = col_e + DIM_W'(1);
    row_inc   = row_e + DIM_W'(1);
    wrap_col  = col_inc >= dw;
    frame_end = wrap_col && (row_inc >= dh);

    tx     = (dw - sw) >> 1;
    ty     = (dh - sh) >> 1;
    tx_end = {1'b0, tx} + {1'b0, sw};
    ty_end = {1'b0, ty} + {1'b0, sh};
    in_box = (col_e >= tx) && ({1'b0, col_e} < tx_end)
          && (row_e >= ty) && ({1'b0, row_e} < ty_end);
    ex     = col_e - tx;
    ey     = row_e - ty;

    mul_x = PW'(col_e) * PW'(sw);
    mul_y = PW'(row_e) * PW'(sh);
    mul_a = PW'(prod_r[DIM_W-1:0]) * PW'(sw) + PW'(qx_r);
    mul_e = in_box ? (PW'(ey) * PW'(sw) + PW'(ex)) : '0;

    rem_sh  = {rem_r, prod_r[PW-1]};
    rem_ge  = rem_sh >= {1'b0, divisor_r};
    // The default store depth is a power of two, so the address wraps by dropping high bits.
    rd_addr = PIX_AW'(prod_r);
  end

  always_comb begin
    src_w_nxt = src_w_r;
    src_h_nxt = src_h_r;
    dst_w_nxt = dst_w_r;
    dst_h_nxt = dst_h_r;
    pb_nxt    = pb_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SRC_WIDTH:   src_w_nxt = cfg_data;
        REG_SRC_HEIGHT:  src_h_nxt = cfg_data;
        REG_DST_WIDTH:   dst_w_nxt = cfg_data;
        REG_DST_HEIGHT:  dst_h_nxt = cfg_data;
        REG_PIXEL_BYTES: pb_nxt    = cfg_data[PB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col_nxt        = col_r;
    row_nxt        = row_r;
    load_idx_nxt   = load_idx_r;
    prod_nxt       = prod_r;
    rem_nxt        = rem_r;
    divisor_nxt    = divisor_r;
    cnt_nxt        = cnt_r;
    qx_nxt         = qx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_pixel_nxt  = out_pixel_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    if (cmd_i.load) begin
      load_idx_nxt = (load_idx_r == PIX_AW'(MAX_PIXELS - 1)) ? '0 : load_idx_r + PIX_AW'(1);
    end

    case (cmd_i.op)
      OP_FIX: begin
        if (pos_bad) begin
          col_nxt = '0;
          row_nxt = '0;
        end
      end
      OP_MULX, OP_MULY: begin
        rem_nxt = '0;
        cnt_nxt = CNT_W'(PW);
        case (cmd_i.op)
          OP_MULX: begin
            prod_nxt    = mul_x;
            divisor_nxt = DV_W'(dw);
          end
          default: begin
            prod_nxt    = mul_y;
            divisor_nxt = DV_W'(dh);
            qx_nxt      = prod_r[DIM_W-1:0];
          end
        endcase
      end
      OP_MULA: prod_nxt = mul_a;
      OP_MULE: prod_nxt = mul_e;
      OP_STEP: begin
        cnt_nxt  = cnt_r - CNT_W'(1);
        prod_nxt = {prod_r[PW-2:0], rem_ge};
        rem_nxt  = rem_ge ? DV_W'(rem_sh - {1'b0, divisor_r}) : rem_sh[DV_W-1:0];
      end
      OP_EMIT: begin
        out_valid_nxt  = 1'b1;
        out_pixel_nxt  = rdata_r & mask;
        out_status_nxt = STAT_OK;
        out_last_nxt   = frame_end;
        if (wrap_col) begin
          col_nxt = '0;
          row_nxt = frame_end ? '0 : CW'(row_inc);
        end else begin
          col_nxt = CW'(col_inc);
        end
        if (frame_end) begin
          load_idx_nxt = '0;
        end
      end
      OP_ERR: begin
        out_valid_nxt  = 1'b1;
        out_pixel_nxt  = '0;
        out_status_nxt = status;
        out_last_nxt   = 1'b1;
        col_nxt        = '0;
        row_nxt        = '0;
        load_idx_nxt   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r     <= CFG_DIM_RESET;
      src_h_r     <= CFG_DIM_RESET;
      dst_w_r     <= CFG_DIM_RESET;
      dst_h_r     <= CFG_DIM_RESET;
      pb_r        <= PB_RESET;
      col_r       <= '0;
      row_r       <= '0;
      load_idx_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      src_w_r     <= src_w_nxt;
      src_h_r     <= src_h_nxt;
      dst_w_r     <= dst_w_nxt;
      dst_h_r     <= dst_h_nxt;
      pb_r        <= pb_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      load_idx_r  <= load_idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= prod_nxt;
    rem_r        <= rem_nxt;
    divisor_r    <= divisor_nxt;
    qx_r         <= qx_nxt;
    out_pixel_r  <= out_pixel_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      mem[load_idx_r] <= in_src_pixel & mask;
    end
    if (cmd_i.op == OP_READ) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign sts_o.status   = status;
  assign sts_o.enlarge  = enlarge;
  assign sts_o.div_done = (cnt_r == '0);
  assign sts_o.out_full = out_valid_r && !out_ready;

  assign out_valid  = out_valid_r;
  assign out_pixel  = out_pixel_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

// ===== hdl/nearest_neighbor_image_resize.sv =====
// Channel  Handshake            Payload
// in       in_valid/in_ready    in_req_type, in_src_pixel
// out      out_valid/out_ready  out_pixel, out_status, out_last
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load item is taken in the idle state and written to the frame store at once.
// A fetch is slowest when shrinking, set by the shared divider that retires one
// quotient bit per cycle for each coordinate, faster when enlarging and fastest on
// a size error. The block goes back to idle before it takes the next item. Reset
// is synchronous and needs no clearing pass. A result waits in the output register,
// and the block holds its last step while it is full.
// Top level of the nearest neighbor image resizer; uses nnir_pkg,
// nnir_ctrl, nnir_dp and the assertion macro header.
`timescale 1ns / 1ps
`include "nearest_neighbor_image_resize_assert.svh"

module nearest_neighbor_image_resize #(
  parameter int MAX_DIM    = nnir_pkg::DEF_MAX_DIM,
  parameter int MAX_PIXELS = nnir_pkg::DEF_MAX_PIXELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [nnir_pkg::PIX_W-1:0]      in_src_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [nnir_pkg::PIX_W-1:0]      out_pixel,
  output logic [nnir_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nnir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnir_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nnir_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  nnir_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  nnir_dp #(
    .MAX_DIM    (MAX_DIM),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_src_pixel (in_src_pixel),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_pixel    (out_pixel),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  `NNIR_ASSERT_NOW(a_err_last_zero, out_valid && (out_status != STAT_OK), out_last && (out_pixel == '0), "Error result without last or with nonzero pixel.")
  `NNIR_ASSERT_NOW(a_status_code, out_valid, (out_status == STAT_OK) || (out_status == STAT_NARROW) || (out_status == STAT_SHORT), "Result status code out of range.")
  `NNIR_ASSERT_NEXT(a_fetch_busy, in_valid && in_ready && in_req_type, !in_ready, "Input taken while a fetch item is in progress.")
  `NNIR_ASSERT_NEXT(a_load_no_result, in_valid && in_ready && !in_req_type && !out_valid, !out_valid, "A load item produced a result.")

endmodule

// ===== tb/nnir_checker.sv =====
// Scoreboard for the nearest neighbor image resizer: watches the configuration, pixel and
// result channels, predicts every fetch from its own frame store copy and compares results.
// Depends on nnir_pkg for widths, status codes and register indexes.
`timescale 1ns / 1ps

module nnir_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [nnir_pkg::PIX_W-1:0]      in_src_pixel,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [nnir_pkg::PIX_W-1:0]      out_pixel,
  input  logic [nnir_pkg::STATUS_W-1:0]   out_status,
  input  logic                            out_last,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [nnir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnir_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import nnir_pkg::*;

  localparam logic REQ_FETCH = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0]    pixel;
    logic [STATUS_W-1:0] status;
    logic                last;
  } resize_result_t;

  logic [PIX_W-1:0]     frame_mem [DEF_MAX_PIXELS];
  logic [CFG_DIM_W-1:0] src_w, src_h, dst_w, dst_h;
  logic [PB_W-1:0]      pix_bytes;
  int unsigned          wr_ptr, col, row;
  int                   mismatches = 0;
  resize_result_t       pixel_q [$];

  function automatic int unsigned eff_dim(input logic [CFG_DIM_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DEF_MAX_DIM) return DEF_MAX_DIM;
    return raw;
  endfunction

  function automatic logic [PIX_W-1:0] pixel_mask();
    if (pix_bytes >= 4) return '1;
    if (pix_bytes <= 1) return 32'h0000_00ff;
    return (32'h1 << (8 * pix_bytes)) - 1;
  endfunction

  // Works out the next output pixel and moves the raster position on.
  function automatic resize_result_t next_pixel();
    int unsigned sw, sh, dw, dh, x, y, tx, ty, addr;
    bit grow;
    resize_result_t r;
    sw = eff_dim(src_w);
    sh = eff_dim(src_h);
    dw = eff_dim(dst_w);
    dh = eff_dim(dst_h);
    if (col >= dw || row >= dh) begin
      col = 0;
      row = 0;
    end
    x = col;
    y = row;
    grow = (dw > sw) || (dh > sh);
    r.pixel = '0;
    r.status = STAT_OK;
    r.last = 1'b0;
    if (grow && dw < sw) begin
      r.status = STAT_NARROW;
    end else if (grow && dh < sh) begin
      r.status = STAT_SHORT;
    end
    if (r.status != STAT_OK) begin
      r.last = 1'b1;
      col = 0;
      row = 0;
      wr_ptr = 0;
      return r;
    end
    if (grow) begin
      tx = (dw - sw) / 2;
      ty = (dh - sh) / 2;
      if (x >= tx && x < tx + sw && y >= ty && y < ty + sh) begin
        addr = (y - ty) * sw + (x - tx);
      end else begin
        addr = 0;
      end
    end else begin
      addr = (y * sh / dh) * sw + x * sw / dw;
    end
    r.pixel = frame_mem[addr % DEF_MAX_PIXELS] & pixel_mask();
    col = x + 1;
    if (col >= dw) begin
      col = 0;
      row = y + 1;
      if (row >= dh) begin
        row = 0;
        wr_ptr = 0;
        r.last = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic [PIX_W-1:0] want,
                             input logic [PIX_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    resize_result_t want;
    if (!rst_n) begin
      src_w = CFG_DIM_RESET;
      src_h = CFG_DIM_RESET;
      dst_w = CFG_DIM_RESET;
      dst_h = CFG_DIM_RESET;
      pix_bytes = PB_RESET;
      wr_ptr = 0;
      col = 0;
      row = 0;
      pixel_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_SRC_WIDTH: src_w = cfg_data;
          REG_SRC_HEIGHT: src_h = cfg_data;
          REG_DST_WIDTH: dst_w = cfg_data;
          REG_DST_HEIGHT: dst_h = cfg_data;
          REG_PIXEL_BYTES: pix_bytes = cfg_data[PB_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, expected none, actual pixel %0h status %0d last %0b",
                   $time, out_pixel, out_status, out_last);
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel", want.pixel, out_pixel);
          check_field("status", want.status, out_status);
          check_field("last", want.last, out_last);
        end
      end
      if (in_valid && in_ready) begin
        if (in_req_type == REQ_FETCH) begin
          pixel_q.push_back(next_pixel());
        end else begin
          frame_mem[wr_ptr] = in_src_pixel & pixel_mask();
          wr_ptr = (wr_ptr + 1) % DEF_MAX_PIXELS;
        end
      end
    end
    pending <= pixel_q.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the nearest neighbor image resizer testbench: clock, reset, pixel and configuration
// stimulus, result back-pressure and the final verdict. Depends on nnir_pkg, nnir_checker
// and the nearest_neighbor_image_resize RTL.
`timescale 1ns / 1ps

module tb_top;
  import nnir_pkg::*;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_FETCH   = 1'b1;
  localparam int   SETTLE      = 4;
  localparam int   HOLD_LEN    = 500;
  localparam int   PHASE_ITEMS = 200;
  localparam int   DRAIN_LIMIT = 100000;
  localparam int   DIM_RAW_MAX = (1 << CFG_DIM_W) - 1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = REQ_LOAD;
  logic [PIX_W-1:0]      in_src_pixel = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_pixel;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;

  int   gap_pct = 0;
  int   stall_pct = 0;
  logic hold_arm = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_cnt = 0;

  int eff_sw = DEF_MAX_DIM, eff_sh = DEF_MAX_DIM, eff_dw = DEF_MAX_DIM, eff_dh = DEF_MAX_DIM;
  int wr_pos = 0, col = 0, row = 0, loaded = 0;
  int n_loads = 0, n_fetches = 0, n_errors = 0, n_cfgs = 0;
  int phase_start, k, drain;

  nearest_neighbor_image_resize dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_src_pixel(in_src_pixel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pixel   (out_pixel),
    .out_status  (out_status),
    .out_last    (out_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  nnir_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_src_pixel(in_src_pixel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pixel   (out_pixel),
    .out_status  (out_status),
    .out_last    (out_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_arm != hold_ack) begin
      out_ready <= 1'b0;
      if (hold_cnt == HOLD_LEN) begin
        hold_ack <= hold_arm;
        hold_cnt <= 0;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic int clamp_dim(input logic [CFG_DIM_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DEF_MAX_DIM) return DEF_MAX_DIM;
    return raw;
  endfunction

  function automatic bit size_error();
    return (eff_dw > eff_sw || eff_dh > eff_sh) && (eff_dw < eff_sw || eff_dh < eff_sh);
  endfunction

  // A fetch must never read a store entry that was not loaded since reset.
  function automatic bit fetch_legal();
    return size_error() || loaded >= eff_sw * eff_sh;
  endfunction

  function automatic int frame_left();
    if (size_error()) return 1;
    if (col >= eff_dw || row >= eff_dh) return eff_dw * eff_dh;
    return eff_dw * eff_dh - (row * eff_dw + col);
  endfunction

  function automatic logic [CFG_DIM_W-1:0] alias_dim(input int v);
    if (v == 1 && $urandom_range(1)) return 0;
    if (v == DEF_MAX_DIM && $urandom_range(1)) return $urandom_range(DEF_MAX_DIM + 1, DIM_RAW_MAX);
    return v;
  endfunction

  task automatic put_item(input logic req, input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_src_pixel <= px;
    do @(posedge clk); while (!in_ready);
    if (req == REQ_LOAD) begin
      n_loads++;
      if (wr_pos == loaded) loaded++;
      wr_pos = (wr_pos + 1) % DEF_MAX_PIXELS;
    end else begin
      n_fetches++;
      if (col >= eff_dw || row >= eff_dh) begin
        col = 0;
        row = 0;
      end
      if (size_error()) begin
        n_errors++;
        col = 0;
        row = 0;
        wr_pos = 0;
      end else begin
        col++;
        if (col >= eff_dw) begin
          col = 0;
          row++;
          if (row >= eff_dh) begin
            row = 0;
            wr_pos = 0;
          end
        end
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [CFG_DIM_W-1:0] sw, input logic [CFG_DIM_W-1:0] sh,
                            input logic [CFG_DIM_W-1:0] dw, input logic [CFG_DIM_W-1:0] dh,
                            input logic [PB_W-1:0] pb);
    wait_idle();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_PIXEL_BYTES, {{(CFG_DATA_W - PB_W){1'b0}}, pb});
    cfg_valid <= 1'b0;
    eff_sw = clamp_dim(sw);
    eff_sh = clamp_dim(sh);
    eff_dw = clamp_dim(dw);
    eff_dh = clamp_dim(dh);
    n_cfgs++;
  endtask

  task automatic rand_config();
    int sw, sh, dw, dh, pick;
    sw = $urandom_range(1, 8);
    sh = $urandom_range(1, 8);
    pick = $urandom_range(99);
    if (pick < 8) begin
      sw = DEF_MAX_DIM;
      sh = $urandom_range(1, 2);
    end else if (pick < 16) begin
      sh = DEF_MAX_DIM;
      sw = $urandom_range(1, 2);
    end
    pick = $urandom_range(99);
    if (pick < 45) begin
      dw = ($urandom_range(3) == 0) ? sw : $urandom_range(1, (sw > 8) ? 8 : sw);
      dh = ($urandom_range(3) == 0) ? sh : $urandom_range(1, (sh > 8) ? 8 : sh);
    end else if (pick < 88) begin
      dw = sw + ((sw * sh > 64) ? 0 : $urandom_range(0, 6));
      dh = sh + ((sw * sh > 64) ? 0 : $urandom_range(0, 6));
    end else if (sw > 1 && sh < DEF_MAX_DIM && (sh == 1 || $urandom_range(1))) begin
      dw = $urandom_range(1, sw - 1);
      dh = sh + 1;
    end else if (sh > 1 && sw < DEF_MAX_DIM) begin
      dh = $urandom_range(1, sh - 1);
      dw = sw + 1;
    end else begin
      dw = sw + 1;
      dh = sh;
    end
    set_config(alias_dim(sw), alias_dim(sh), alias_dim(dw), alias_dim(dh),
               $urandom_range(0, 7));
  endtask

  task automatic run_frame();
    if (eff_sw * eff_sh <= 300 || !fetch_legal()) begin
      repeat (eff_sw * eff_sh) put_item(REQ_LOAD, $urandom);
    end
    repeat (frame_left()) put_item(REQ_FETCH, $urandom);
  endtask

  initial begin
    #20ms;
    $display("Timeout at %0t ns with %0d results outstanding", $time, pending);
    $display("[nearest_neighbor_image_resize] ERROR");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(2, 2, 2, 2, 4);
    put_item(REQ_LOAD, 32'h0000_0000);
    put_item(REQ_LOAD, 32'hffff_ffff);
    put_item(REQ_LOAD, 32'h8000_0001);
    put_item(REQ_LOAD, 32'h7fff_fffe);
    repeat (3) put_item(REQ_FETCH, $urandom);
    // The output shrinks under the current position, so the frame restarts.
    set_config(2, 2, 2, 1, 0);
    repeat (2) put_item(REQ_FETCH, $urandom);
    set_config(2, 2, 4, 3, 7);
    repeat (12) put_item(REQ_FETCH, $urandom);
    set_config(2, 2, 1, 3, 1);
    put_item(REQ_FETCH, $urandom);
    set_config(2, 2, 3, 1, 2);
    put_item(REQ_FETCH, $urandom);
    set_config(0, 0, 0, 0, 3);
    put_item(REQ_FETCH, $urandom);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0; stall_pct <= 0; end
        1: begin gap_pct = 82; stall_pct <= 0; end
        2: begin gap_pct = 0; stall_pct <= 82; end
        default: begin gap_pct = 23; stall_pct <= 23; end
      endcase
      phase_start = n_loads + n_fetches;
      set_config(8, 8, 6, 6, 4);
      hold_arm <= ~hold_arm;
      run_frame();
      while (n_loads + n_fetches < phase_start + PHASE_ITEMS) begin
        if ($urandom_range(99) < 35) rand_config();
        k = $urandom_range(99);
        if (k < 65 || !fetch_legal()) begin
          run_frame();
        end else if (k < 80) begin
          repeat ($urandom_range(1, 20)) begin
            put_item(($urandom_range(1) && fetch_legal()) ? REQ_FETCH : REQ_LOAD, $urandom);
          end
        end else begin
          repeat ($urandom_range(1, frame_left())) put_item(REQ_FETCH, $urandom);
          wait_idle();
          repeat ($urandom_range(0, frame_left())) put_item(REQ_FETCH, $urandom);
        end
      end
    end

    in_valid <= 1'b0;
    drain = 0;
    @(posedge clk);
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (4 * SETTLE) @(posedge clk);
    $display("Run covered %0d loads and %0d fetches (%0d size errors) over %0d register settings,",
             n_loads, n_fetches, n_errors, n_cfgs);
    $display("with mid-frame resizes, a long output stall and four idling patterns.");
    if (fail_count == 0 && pending == 0) begin
      $display("[nearest_neighbor_image_resize] OK");
    end else begin
      if (pending != 0) $display("%0d expected results never arrived", pending);
      $display("[nearest_neighbor_image_resize] ERROR");
    end
    $finish;
  end

endmodule
